FILE: src/tecc_pkg.sv
package tecc_pkg;

  // Field widths
  localparam int unsigned CurrentWidth = 24;
  localparam int unsigned TimeWidth    = 40;
  localparam int unsigned VoltWidth    = 16;
  localparam int unsigned GapWidth     = 16;
  localparam int unsigned AccWidth     = 64;
  localparam int unsigned OpWidth      = 2;

  // Shared multiplier: CurrentWidth x MulBWidth
  localparam int unsigned MulBWidth    = (VoltWidth > GapWidth) ? VoltWidth : GapWidth;
  localparam int unsigned ProdWidth    = CurrentWidth + MulBWidth;
  localparam int unsigned HiProdWidth  = ProdWidth - CurrentWidth + MulBWidth;
  localparam int unsigned EnergyWidth  = ProdWidth + MulBWidth;

  // Configuration port
  localparam int unsigned CfgDataWidth = 64;
  localparam int unsigned CfgAddrWidth = 5;
  localparam int unsigned CfgIdxLsb    = 3;
  localparam int unsigned CfgIdxWidth  = CfgAddrWidth - CfgIdxLsb;

  localparam logic [CfgIdxWidth-1:0] REG_MAX_GAP        = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_SAVE_INTERVAL  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_VALID_TIME_MIN = 2'd2;

  localparam logic [GapWidth-1:0]  MaxGapReset       = GapWidth'(600);
  localparam logic [GapWidth-1:0]  SaveIntervalReset = GapWidth'(300);
  localparam logic [TimeWidth-1:0] ValidTimeMinReset = TimeWidth'(64'd1000000000);

  localparam logic signed [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
  localparam logic signed [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};

  typedef enum logic [OpWidth-1:0] {
    OP_BATTERY    = 2'd0,
    OP_SOLAR      = 2'd1,
    OP_TRIP_START = 2'd2,
    OP_TRIP_END   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                             operation;
    logic [TimeWidth-1:0]            timestamp_s;
    logic signed [CurrentWidth-1:0]  current_ma;
    logic [VoltWidth-1:0]            voltage_cv;
  } in_req_t;

  typedef struct packed {
    logic signed [AccWidth-1:0] charged_energy;
    logic signed [AccWidth-1:0] discharged_energy;
    logic signed [AccWidth-1:0] charged_charge;
    logic signed [AccWidth-1:0] discharged_charge;
    logic signed [AccWidth-1:0] solar_energy;
    logic signed [AccWidth-1:0] solar_charge;
    logic [TimeWidth-1:0]       running_seconds;
    logic [TimeWidth-1:0]       pv_seconds;
    logic [TimeWidth-1:0]       trip_start_time;
    logic                       trip_active;
    logic                       save_due;
    logic                       sample_used;
  } out_rsp_t;

  typedef struct packed {
    logic [GapWidth-1:0]  max_gap_seconds;
    logic [GapWidth-1:0]  save_interval_seconds;
    logic [TimeWidth-1:0] valid_time_min;
  } cfg_t;

  // Microcode
  typedef logic [3:0] step_t;

  localparam step_t STEP_DONE     = 4'd0;
  localparam step_t STEP_IDLE     = 4'd1;
  localparam step_t STEP_DISPATCH = 4'd2;
  localparam step_t STEP_CHECK    = 4'd3;
  localparam step_t STEP_GAP      = 4'd4;
  localparam step_t STEP_MUL_Q    = 4'd5;
  localparam step_t STEP_MUL_IV   = 4'd6;
  localparam step_t STEP_MUL_LO   = 4'd7;
  localparam step_t STEP_MUL_HI   = 4'd8;
  localparam step_t STEP_SUM_E    = 4'd9;
  localparam step_t STEP_ADD_E    = 4'd10;
  localparam step_t STEP_ADD_Q    = 4'd11;
  localparam step_t STEP_CMD      = 4'd12;

  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_REQ    = 3'd2,
    COND_IS_CMD    = 3'd3,
    COND_CLOCK_BAD = 3'd4,
    COND_NOT_USED  = 3'd5,
    COND_OUT_BUSY  = 3'd6
  } cond_e;

  typedef enum logic [1:0] {
    MA_IMAG   = 2'd0,
    MA_MID_LO = 2'd1,
    MA_MID_HI = 2'd2
  } mul_a_e;

  typedef enum logic {
    MB_DT   = 1'b0,
    MB_VOLT = 1'b1
  } mul_b_e;

  typedef enum logic [2:0] {
    MD_NONE = 3'd0,
    MD_Q    = 3'd1,
    MD_MID  = 3'd2,
    MD_ELO  = 3'd3,
    MD_EHI  = 3'd4
  } mul_dst_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_GAP    = 3'd1,
    ACT_SUM_E  = 3'd2,
    ACT_ADD_E  = 3'd3,
    ACT_ADD_Q  = 3'd4,
    ACT_CMD    = 3'd5,
    ACT_RESULT = 3'd6
  } act_e;

  typedef struct packed {
    cond_e    cond;
    step_t    target;
    mul_a_e   mul_a;
    mul_b_e   mul_b;
    mul_dst_e mul_dst;
    act_e     act;
  } ucode_t;

  typedef struct packed {
    logic is_cmd;
    logic clock_bad;
    logic not_used;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: src/tecc_if.sv
interface tecc_in_if;
  import tecc_pkg::*;

  logic    valid;
  logic    ready;
  in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tecc_out_if;
  import tecc_pkg::*;

  logic     valid;
  logic     ready;
  out_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/tecc_apb_regs.sv
module tecc_apb_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tecc_pkg::CfgAddrWidth-1:0]   paddr,
  input  logic [tecc_pkg::CfgDataWidth-1:0]   pwdata,
  output logic [tecc_pkg::CfgDataWidth-1:0]   prdata,
  output logic                                pready,
  output tecc_pkg::cfg_t                      cfg_o
);
  import tecc_pkg::*;

  cfg_t                   cfg_q;
  logic                   wr_en;
  logic [CfgIdxWidth-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[CfgAddrWidth-1:CfgIdxLsb];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_gap_seconds       <= MaxGapReset;
      cfg_q.save_interval_seconds <= SaveIntervalReset;
      cfg_q.valid_time_min        <= ValidTimeMinReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAX_GAP:        cfg_q.max_gap_seconds       <= pwdata[GapWidth-1:0];
        REG_SAVE_INTERVAL:  cfg_q.save_interval_seconds <= pwdata[GapWidth-1:0];
        REG_VALID_TIME_MIN: cfg_q.valid_time_min        <= pwdata[TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_GAP:        prdata = CfgDataWidth'(cfg_q.max_gap_seconds);
      REG_SAVE_INTERVAL:  prdata = CfgDataWidth'(cfg_q.save_interval_seconds);
      REG_VALID_TIME_MIN: prdata = CfgDataWidth'(cfg_q.valid_time_min);
      default:            prdata = '0;
    endcase
  end

endmodule

FILE: src/tecc_sequencer.sv
module tecc_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tecc_pkg::dp_status_t status_i,
  output tecc_pkg::ucode_t     ucode_o
);
  import tecc_pkg::*;

  step_t  step_q, step_d;
  ucode_t uc;
  logic   take;

  function automatic ucode_t uword(cond_e c, step_t t, mul_a_e ma, mul_b_e mb,
                                   mul_dst_e md, act_e a);
    ucode_t w;
    w.cond    = c;
    w.target  = t;
    w.mul_a   = ma;
    w.mul_b   = mb;
    w.mul_dst = md;
    w.act     = a;
    return w;
  endfunction

  // Microprogram; a step whose condition fails falls through to the next address.
  function automatic ucode_t rom_word(step_t s);
    ucode_t w;
    unique case (s)
      STEP_DONE:     w = uword(COND_OUT_BUSY, STEP_DONE, MA_IMAG, MB_DT, MD_NONE, ACT_RESULT);
      STEP_IDLE:     w = uword(COND_NO_REQ, STEP_IDLE, MA_IMAG, MB_DT, MD_NONE, ACT_NONE);
      STEP_DISPATCH: w = uword(COND_IS_CMD, STEP_CMD, MA_IMAG, MB_DT, MD_NONE, ACT_NONE);
      STEP_CHECK:    w = uword(COND_CLOCK_BAD, STEP_DONE, MA_IMAG, MB_DT, MD_NONE, ACT_NONE);
      STEP_GAP:      w = uword(COND_NOT_USED, STEP_DONE, MA_IMAG, MB_DT, MD_NONE, ACT_GAP);
      STEP_MUL_Q:    w = uword(COND_NEVER, STEP_IDLE, MA_IMAG, MB_DT, MD_Q, ACT_NONE);
      STEP_MUL_IV:   w = uword(COND_NEVER, STEP_IDLE, MA_IMAG, MB_VOLT, MD_MID, ACT_NONE);
      STEP_MUL_LO:   w = uword(COND_NEVER, STEP_IDLE, MA_MID_LO, MB_DT, MD_ELO, ACT_NONE);
      STEP_MUL_HI:   w = uword(COND_NEVER, STEP_IDLE, MA_MID_HI, MB_DT, MD_EHI, ACT_NONE);
      STEP_SUM_E:    w = uword(COND_NEVER, STEP_IDLE, MA_IMAG, MB_DT, MD_NONE, ACT_SUM_E);
      STEP_ADD_E:    w = uword(COND_NEVER, STEP_IDLE, MA_IMAG, MB_DT, MD_NONE, ACT_ADD_E);
      STEP_ADD_Q:    w = uword(COND_ALWAYS, STEP_DONE, MA_IMAG, MB_DT, MD_NONE, ACT_ADD_Q);
      STEP_CMD:      w = uword(COND_ALWAYS, STEP_DONE, MA_IMAG, MB_DT, MD_NONE, ACT_CMD);
      default:       w = uword(COND_ALWAYS, STEP_IDLE, MA_IMAG, MB_DT, MD_NONE, ACT_NONE);
    endcase
    return w;
  endfunction

  assign uc         = rom_word(step_q);
  assign ucode_o    = uc;
  assign in_ready_o = (step_q == STEP_IDLE);

  always_comb begin
    unique case (uc.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_REQ:    take = !in_valid_i;
      COND_IS_CMD:    take = status_i.is_cmd;
      COND_CLOCK_BAD: take = status_i.clock_bad;
      COND_NOT_USED:  take = status_i.not_used;
      COND_OUT_BUSY:  take = status_i.out_busy;
      default:        take = 1'b1;
    endcase
    step_d = take ? uc.target : step_t'(step_q + step_t'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

FILE: src/tecc_datapath.sv
module tecc_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tecc_pkg::cfg_t       cfg_i,
  input  tecc_pkg::ucode_t     ucode_i,
  input  logic                 accept_i,
  input  tecc_pkg::in_req_t    req_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output tecc_pkg::out_rsp_t   rsp_o,
  output tecc_pkg::dp_status_t status_o
);
  import tecc_pkg::*;

  // Latched request
  op_e                     op_q;
  logic [TimeWidth-1:0]    now_q;
  logic [CurrentWidth-1:0] imag_q;
  logic                    neg_q;
  logic [VoltWidth-1:0]    volt_q;

  // Working registers
  logic [GapWidth-1:0]     dt_q;
  logic [ProdWidth-1:0]    q_q;
  logic [ProdWidth-1:0]    mid_q;
  logic [ProdWidth-1:0]    elo_q;
  logic [HiProdWidth-1:0]  ehi_q;
  logic [EnergyWidth-1:0]  e_q;

  // Accumulators and trip state
  logic signed [AccWidth-1:0] ce_q, de_q, cc_q, dc_q, se_q, sc_q;
  logic [TimeWidth-1:0]       rs_q, ss_q;
  logic [TimeWidth-1:0]       trip_start_q;
  logic                       trip_open_q;
  logic [TimeWidth-1:0]       last_bat_q, last_sol_q, last_save_q;
  logic                       save_q, used_q;

  out_rsp_t rsp_q;
  logic     out_valid_q;

  logic                    cur_neg;
  logic [CurrentWidth-1:0] cur_mag;
  logic                    is_solar, pos, chg;
  logic [TimeWidth-1:0]    last_sel;
  logic [TimeWidth-1:0]    diff;
  logic                    gap_ok, use_now, clock_bad, out_busy;
  logic [CurrentWidth-1:0] mul_a;
  logic [MulBWidth-1:0]    mul_b;
  logic [ProdWidth-1:0]    prod;
  logic signed [AccWidth-1:0] e_add, q_add, add_a, add_b, add_sum;
  logic [TimeWidth-1:0]    sec_sel, sec_new;
  logic [TimeWidth:0]      sec_sum;
  logic                    save_hit;

  function automatic logic signed [AccWidth-1:0] sat_add(
    input logic signed [AccWidth-1:0] a,
    input logic signed [AccWidth-1:0] b
  );
    logic signed [AccWidth-1:0] s;
    s = a + b;
    if ((a[AccWidth-1] == b[AccWidth-1]) && (s[AccWidth-1] != a[AccWidth-1])) begin
      s = a[AccWidth-1] ? AccMin : AccMax;
    end
    return s;
  endfunction

  // Magnitude of the incoming current; the most negative code maps to 2^(w-1).
  assign cur_neg = req_i.current_ma[CurrentWidth-1];
  assign cur_mag = cur_neg ? CurrentWidth'(~req_i.current_ma + 1'b1)
                           : CurrentWidth'(req_i.current_ma);

  assign is_solar  = (op_q == OP_SOLAR);
  assign pos       = !neg_q && (imag_q != '0);
  assign chg       = pos && (volt_q != '0);
  assign clock_bad = (now_q < cfg_i.valid_time_min);
  assign out_busy  = out_valid_q && !out_ready_i;

  // Elapsed time since the previous sample of the same kind
  assign last_sel = is_solar ? last_sol_q : last_bat_q;
  assign diff     = now_q - last_sel;
  assign gap_ok   = (last_sel != '0) && (now_q > last_sel)
                    && (diff < TimeWidth'(cfg_i.max_gap_seconds));
  assign use_now  = gap_ok && (!is_solar || pos);

  assign status_o.is_cmd    = (op_q == OP_TRIP_START) || (op_q == OP_TRIP_END);
  assign status_o.clock_bad = clock_bad;
  assign status_o.not_used  = !use_now;
  assign status_o.out_busy  = out_busy;

  // Shared multiplier
  always_comb begin
    unique case (ucode_i.mul_a)
      MA_IMAG:   mul_a = imag_q;
      MA_MID_LO: mul_a = mid_q[CurrentWidth-1:0];
      MA_MID_HI: mul_a = CurrentWidth'(mid_q[ProdWidth-1:CurrentWidth]);
      default:   mul_a = imag_q;
    endcase
    unique case (ucode_i.mul_b)
      MB_DT:   mul_b = MulBWidth'(dt_q);
      MB_VOLT: mul_b = MulBWidth'(volt_q);
      default: mul_b = MulBWidth'(dt_q);
    endcase
  end

  assign prod = ProdWidth'(mul_a) * ProdWidth'(mul_b);

  // Shared saturating accumulator adder
  assign e_add = AccWidth'(e_q);
  assign q_add = AccWidth'(q_q);

  always_comb begin
    add_a = dc_q;
    add_b = q_add;
    if (ucode_i.act == ACT_ADD_E) begin
      add_b = e_add;
      if (is_solar)   add_a = se_q;
      else if (chg)   add_a = ce_q;
      else            add_a = de_q;
    end else begin
      if (is_solar)   add_a = sc_q;
      else if (chg)   add_a = cc_q;
      else if (neg_q) add_a = dc_q;
      else begin
        add_a = dc_q;
        add_b = -q_add;
      end
    end
  end

  assign add_sum = sat_add(add_a, add_b);

  // Seconds counters saturate at the top of their range
  assign sec_sel  = is_solar ? ss_q : rs_q;
  assign sec_sum  = {1'b0, sec_sel} + (TimeWidth + 1)'(dt_q);
  assign sec_new  = sec_sum[TimeWidth] ? '1 : sec_sum[TimeWidth-1:0];
  assign save_hit = (now_q >= last_save_q)
                    && ((now_q - last_save_q) >= TimeWidth'(cfg_i.save_interval_seconds));

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      op_q   <= req_i.operation;
      now_q  <= req_i.timestamp_s;
      imag_q <= cur_mag;
      neg_q  <= cur_neg;
      volt_q <= req_i.voltage_cv;
    end
    if (ucode_i.act == ACT_GAP) begin
      dt_q <= diff[GapWidth-1:0];
    end
    unique case (ucode_i.mul_dst)
      MD_Q:    q_q   <= prod;
      MD_MID:  mid_q <= prod;
      MD_ELO:  elo_q <= prod;
      MD_EHI:  ehi_q <= prod[HiProdWidth-1:0];
      default: ;
    endcase
    if (ucode_i.act == ACT_SUM_E) begin
      e_q <= EnergyWidth'(elo_q) + (EnergyWidth'(ehi_q) << CurrentWidth);
    end
    if ((ucode_i.act == ACT_RESULT) && !out_busy) begin
      rsp_q.charged_energy    <= ce_q;
      rsp_q.discharged_energy <= de_q;
      rsp_q.charged_charge    <= cc_q;
      rsp_q.discharged_charge <= dc_q;
      rsp_q.solar_energy      <= se_q;
      rsp_q.solar_charge      <= sc_q;
      rsp_q.running_seconds   <= rs_q;
      rsp_q.pv_seconds        <= ss_q;
      rsp_q.trip_start_time   <= trip_start_q;
      rsp_q.trip_active       <= trip_open_q;
      rsp_q.save_due          <= save_q;
      rsp_q.sample_used       <= used_q;
    end
  end

  // Architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ce_q         <= '0;
      de_q         <= '0;
      cc_q         <= '0;
      dc_q         <= '0;
      se_q         <= '0;
      sc_q         <= '0;
      rs_q         <= '0;
      ss_q         <= '0;
      trip_start_q <= '0;
      trip_open_q  <= 1'b1;
      last_bat_q   <= '0;
      last_sol_q   <= '0;
      last_save_q  <= '0;
      save_q       <= 1'b0;
      used_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept_i) begin
        save_q <= 1'b0;
        used_q <= 1'b0;
      end
      unique case (ucode_i.act)
        ACT_GAP: begin
          if (is_solar) begin
            last_sol_q <= now_q;
          end else begin
            last_bat_q <= now_q;
            if (trip_start_q == '0) trip_start_q <= now_q;
          end
        end
        ACT_ADD_E: begin
          if (is_solar)   se_q <= add_sum;
          else if (chg)   ce_q <= add_sum;
          else if (neg_q) de_q <= add_sum;
        end
        ACT_ADD_Q: begin
          used_q <= 1'b1;
          if (is_solar) begin
            sc_q <= add_sum;
            ss_q <= sec_new;
          end else begin
            if (chg) cc_q <= add_sum;
            else     dc_q <= add_sum;
            rs_q <= sec_new;
            if (save_hit) begin
              save_q      <= 1'b1;
              last_save_q <= now_q;
            end
          end
        end
        ACT_CMD: begin
          if (op_q == OP_TRIP_START) begin
            ce_q         <= '0;
            de_q         <= '0;
            cc_q         <= '0;
            dc_q         <= '0;
            se_q         <= '0;
            sc_q         <= '0;
            rs_q         <= '0;
            ss_q         <= '0;
            last_bat_q   <= '0;
            last_sol_q   <= '0;
            trip_start_q <= clock_bad ? '0 : now_q;
            trip_open_q  <= 1'b1;
          end else begin
            trip_open_q  <= 1'b0;
          end
        end
        default: ;
      endcase
      if ((ucode_i.act == ACT_RESULT) && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

endmodule

FILE: src/trip_energy_charge_counter.sv
// Trip energy and charge counter.
// Requests enter on in_i (valid/ready): a battery sample, a solar sample, a
// start-new-trip or an end-trip command, each stamped with wall clock seconds.
// Every request yields exactly one result on out_o: a snapshot of all
// accumulators, the trip state and the save_due / sample_used flags.
// From request accept to result valid, an integrated sample walks dispatch,
// clock check, gap check, four products, the energy sum and two adds; a
// sample with an unusable gap ends after the gap step, a command after its
// command step and a sample taken while the clock is not yet valid after the
// clock check. No new request is accepted until the result register loads.
// The four products go through the one shared 24x16 multiplier and the two
// adds through the shared 64-bit saturating adder.
// The result sits in an output register: the next request is accepted while
// it waits. If out_o stalls, the sequencer holds in its final step until the
// register frees, and in_i stays not ready meanwhile.
// Reset clears all accumulators and sample times, opens a trip and loads the
// configuration defaults (gap 600 s, save interval 300 s, valid time 1e9 s).
// Configuration is written via APB-style port only while idle: user's duty.
module trip_energy_charge_counter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tecc_in_if.sink                           in_i,
  tecc_out_if.source                        out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tecc_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [tecc_pkg::CfgDataWidth-1:0] pwdata,
  output logic [tecc_pkg::CfgDataWidth-1:0] prdata,
  output logic                              pready
);
  import tecc_pkg::*;

  cfg_t       cfg;
  ucode_t     ucode;
  dp_status_t status;
  logic       in_ready;
  logic       accept;

  // Request handshake: ready only while the sequencer sits in its idle step.
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  tecc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Step counter, control store and branch logic
  tecc_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .ucode_o    (ucode)
  );

  // Multiplier, saturating adder, accumulators and output register
  tecc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .ucode_i     (ucode),
    .accept_i    (accept),
    .req_i       (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .rsp_o       (out_o.data),
    .status_o    (status)
  );

endmodule
